/* hw/rtl/mced_pkg.sv */
// Shared types, constants and the Morse code table for the Morse edge timing decoder.
`timescale 1ns / 1ps

package mced_pkg;

    localparam int MAX_SYMBOLS_DEF = 5;

    localparam int CAP_W  = 16;
    localparam int WRAP_W = 8;
    localparam int TICK_W = CAP_W + WRAP_W;
    localparam int CHAR_W = 7;

    localparam logic [TICK_W-1:0] DOT_MIN_RST  = 24'd1875;
    localparam logic [TICK_W-1:0] DASH_MIN_RST = 24'd12500;
    localparam logic [TICK_W-1:0] GAP_MIN_RST  = 24'd25000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN  = 2'd2;

    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [TICK_W-1:0] dot_min;
        logic [TICK_W-1:0] dash_min;
        logic [TICK_W-1:0] gap_min;
    } t_cfg;

    typedef struct packed {
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
        logic              dot_lamp;
        logic              dash_lamp;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic push0;
        logic push1;
    } t_push;

    typedef struct packed {
        logic room2;
    } t_rq_status;

    // Bit i of pat is symbol i of the code, 1 for a dash.
    typedef struct packed {
        logic [2:0]        len;
        logic [4:0]        pat;
        logic [CHAR_W-1:0] ascii;
    } t_morse;

    localparam int MORSE_N = 36;

    localparam t_morse MORSE_TABLE [MORSE_N] = '{
        '{3'd2, 5'b00010, 7'h41}, '{3'd4, 5'b00001, 7'h42}, '{3'd4, 5'b00101, 7'h43},
        '{3'd3, 5'b00001, 7'h44}, '{3'd1, 5'b00000, 7'h45}, '{3'd4, 5'b00100, 7'h46},
        '{3'd3, 5'b00011, 7'h47}, '{3'd4, 5'b00000, 7'h48}, '{3'd2, 5'b00000, 7'h49},
        '{3'd4, 5'b01110, 7'h4A}, '{3'd3, 5'b00101, 7'h4B}, '{3'd4, 5'b00010, 7'h4C},
        '{3'd2, 5'b00011, 7'h4D}, '{3'd2, 5'b00001, 7'h4E}, '{3'd3, 5'b00111, 7'h4F},
        '{3'd4, 5'b00110, 7'h50}, '{3'd4, 5'b01011, 7'h51}, '{3'd3, 5'b00010, 7'h52},
        '{3'd3, 5'b00000, 7'h53}, '{3'd1, 5'b00001, 7'h54}, '{3'd3, 5'b00100, 7'h55},
        '{3'd4, 5'b01000, 7'h56}, '{3'd3, 5'b00110, 7'h57}, '{3'd4, 5'b01001, 7'h58},
        '{3'd4, 5'b01101, 7'h59}, '{3'd4, 5'b00011, 7'h5A},
        '{3'd5, 5'b11110, 7'h31}, '{3'd5, 5'b11100, 7'h32}, '{3'd5, 5'b11000, 7'h33},
        '{3'd5, 5'b10000, 7'h34}, '{3'd5, 5'b00000, 7'h35}, '{3'd5, 5'b00001, 7'h36},
        '{3'd5, 5'b00011, 7'h37}, '{3'd5, 5'b00111, 7'h38}, '{3'd5, 5'b01111, 7'h39},
        '{3'd5, 5'b11111, 7'h30}
    };

endpackage

/* hw/rtl/mced_if.sv */
// Channel interfaces of the Morse edge timing decoder: edge input, result output, config.
`timescale 1ns / 1ps

interface mced_in_if;
    logic                       valid;
    logic                       ready;
    logic [mced_pkg::CAP_W-1:0]  capture_value;
    logic [mced_pkg::WRAP_W-1:0] wraps;

    modport source(output valid, capture_value, wraps, input ready);
    modport sink(input valid, capture_value, wraps, output ready);
endinterface

interface mced_out_if;
    logic                        valid;
    logic                        ready;
    logic                        char_valid;
    logic [mced_pkg::CHAR_W-1:0] char_code;
    logic                        dot_lamp;
    logic                        dash_lamp;
    logic                        last_result;

    modport source(output valid, char_valid, char_code, dot_lamp, dash_lamp, last_result,
                   input ready);
    modport sink(input valid, char_valid, char_code, dot_lamp, dash_lamp, last_result,
                 output ready);
endinterface

interface mced_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mced_pkg::CFG_IDX_W-1:0] index;
    logic [mced_pkg::TICK_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* hw/rtl/mced_core.sv */
// Edge register, timing classification, code assembly and table match of the decoder.
`timescale 1ns / 1ps

module mced_core #(
    parameter int MAX_SYMBOLS = mced_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mced_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mced_pkg::CAP_W-1:0]   i_capture_value,
    input  logic [mced_pkg::WRAP_W-1:0]  i_wraps,
    input  mced_pkg::t_rq_status         i_rq_status,
    output mced_pkg::t_push              o_push,
    output mced_pkg::t_result            o_res0,
    output mced_pkg::t_result            o_res1
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    logic                          r_in_valid;
    logic [mced_pkg::CAP_W-1:0]    r_cap;
    logic [mced_pkg::WRAP_W-1:0]   r_wraps;

    logic                          r_expect_rising, n_expect_rising;
    logic [mced_pkg::CAP_W-1:0]    r_last_edge, n_last_edge;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [MAX_SYMBOLS-1:0]        r_pattern, n_pattern;
    logic                          r_too_long, n_too_long;

    logic                          advance;
    logic [mced_pkg::TICK_W-1:0]   total;
    logic [mced_pkg::TICK_W-1:0]   last_ext;
    logic [mced_pkg::TICK_W-1:0]   elapsed;
    logic                          nonneg;
    logic                          is_gap;
    logic                          is_dot;
    logic                          is_dash;
    logic [mced_pkg::CHAR_W-1:0]   match_char;

    assign advance    = r_in_valid && i_rq_status.room2;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cap   <= i_capture_value;
            r_wraps <= i_wraps;
        end
    end

    // Elapsed time is negative only when there were no wraps and the timer is below the
    // last edge; such an edge counts as neither a symbol nor a gap.
    assign total    = {r_wraps, r_cap};
    assign last_ext = {{mced_pkg::WRAP_W{1'b0}}, r_last_edge};
    assign nonneg   = total >= last_ext;
    assign elapsed  = total - last_ext;
    assign is_gap   = nonneg && (elapsed >= i_cfg.gap_min);
    assign is_dot   = nonneg && (elapsed >= i_cfg.dot_min) && (elapsed < i_cfg.dash_min);
    assign is_dash  = nonneg && (elapsed >= i_cfg.dash_min);

    always_comb begin
        match_char = '0;
        if (!r_too_long && (r_count != '0)) begin
            for (int e = 0; e < mced_pkg::MORSE_N; e++) begin
                if ((r_count == CNT_W'(mced_pkg::MORSE_TABLE[e].len)) &&
                    (r_pattern == MAX_SYMBOLS'(mced_pkg::MORSE_TABLE[e].pat))) begin
                    match_char = match_char | mced_pkg::MORSE_TABLE[e].ascii;
                end
            end
        end
    end

    always_comb begin
        n_expect_rising = r_expect_rising;
        n_last_edge     = r_last_edge;
        n_count         = r_count;
        n_pattern       = r_pattern;
        n_too_long      = r_too_long;
        o_push.push0    = advance;
        o_push.push1    = 1'b0;
        o_res0          = '0;
        o_res1          = '0;
        o_res0.last_result = 1'b1;
        o_res1.last_result = 1'b1;
        o_res1.char_valid  = 1'b1;
        o_res1.char_code   = match_char;

        if (r_expect_rising) begin
            if (is_gap) begin
                o_res0.char_valid  = 1'b1;
                o_res0.char_code   = mced_pkg::ASCII_SPACE;
                o_res0.last_result = (match_char == '0);
                o_push.push1       = advance && (match_char != '0);
            end
        end else begin
            o_res0.dot_lamp  = is_dot;
            o_res0.dash_lamp = is_dash;
        end

        if (advance) begin
            n_expect_rising = !r_expect_rising;
            n_last_edge     = r_cap;
            if (r_expect_rising) begin
                if (is_gap) begin
                    n_count    = '0;
                    n_pattern  = '0;
                    n_too_long = 1'b0;
                end
            end else if (is_dot || is_dash) begin
                if (r_count < CNT_W'(MAX_SYMBOLS)) begin
                    if (is_dash) begin
                        n_pattern = r_pattern | ({{(MAX_SYMBOLS-1){1'b0}}, 1'b1} << r_count);
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    n_too_long = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_rising <= 1'b1;
            r_last_edge     <= '0;
            r_count         <= '0;
            r_pattern       <= '0;
            r_too_long      <= 1'b0;
        end else begin
            r_expect_rising <= n_expect_rising;
            r_last_edge     <= n_last_edge;
            r_count         <= n_count;
            r_pattern       <= n_pattern;
            r_too_long      <= n_too_long;
        end
    end

endmodule

/* hw/rtl/mced_rq.sv */
// Result queue of the decoder: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module mced_rq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mced_pkg::t_push      i_push,
    input  mced_pkg::t_result    i_res0,
    input  mced_pkg::t_result    i_res1,
    output mced_pkg::t_rq_status o_status,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mced_pkg::t_result    o_res
);

    mced_pkg::t_result                 r_mem [mced_pkg::RQ_DEPTH];
    logic [mced_pkg::RQ_PTR_W-1:0]     r_wp, n_wp;
    logic [mced_pkg::RQ_PTR_W-1:0]     r_rp, n_rp;
    logic [mced_pkg::RQ_CNT_W-1:0]     r_count, n_count;
    logic                              pop;

    assign o_valid        = (r_count != '0);
    assign o_res          = r_mem[r_rp];
    assign pop            = o_valid && i_ready;
    assign o_status.room2 = (r_count <= mced_pkg::RQ_CNT_W'(mced_pkg::RQ_DEPTH - 2));

    always_comb begin
        n_wp    = r_wp + mced_pkg::RQ_PTR_W'(i_push.push0) + mced_pkg::RQ_PTR_W'(i_push.push1);
        n_rp    = r_rp + mced_pkg::RQ_PTR_W'(pop);
        n_count = r_count + mced_pkg::RQ_CNT_W'(i_push.push0)
                + mced_pkg::RQ_CNT_W'(i_push.push1) - mced_pkg::RQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push.push1) begin
            r_mem[mced_pkg::RQ_PTR_W'(r_wp + 1'b1)] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/morse_edge_timing_decoder.sv */
// Top level of the Morse edge timing decoder: configuration registers, core and result queue.
//
// Usage: each request on i_in is one key edge, carrying the captured 16-bit timer value and
// the count of timer wraps since the previous edge. Edges alternate between press and
// release, starting with a press after reset. Each edge produces one result on o_out, except
// that a press that ends a letter produces a space and, when the code matches, the letter or
// digit as a second result. last_result marks the final result of an edge.
// i_cfg writes the dot, dash and gap thresholds (index 0, 1, 2); it is always ready, and
// writes to other indexes are dropped. Write it only while no edge is in flight.
// An accepted edge waits in the edge register, where it is classified and matched, and its
// results are written into the result queue, from which o_out offers them.
// Throughput: one edge per cycle while two queue entries are free, set by the single-pass
// classify and match logic between the edge register and the four-entry result queue; an
// edge with two results needs two transfers on the output.
// Reset (synchronous, active low) restores the default thresholds, clears the code, empties
// the result queue and expects a press next.
// When the receiver stalls, results wait in the queue; i_in.ready drops while the edge
// register holds a request and fewer than two queue entries are free, and that request
// waits there until room appears.
`timescale 1ns / 1ps

module morse_edge_timing_decoder #(
    parameter int MAX_SYMBOLS = mced_pkg::MAX_SYMBOLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mced_in_if.sink           i_in,
    mced_out_if.source        o_out,
    mced_cfg_if.sink          i_cfg
);

    mced_pkg::t_cfg       r_cfg;
    mced_pkg::t_push      push;
    mced_pkg::t_result    res0;
    mced_pkg::t_result    res1;
    mced_pkg::t_result    out_res;
    mced_pkg::t_rq_status rq_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_min  <= mced_pkg::DOT_MIN_RST;
            r_cfg.dash_min <= mced_pkg::DASH_MIN_RST;
            r_cfg.gap_min  <= mced_pkg::GAP_MIN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mced_pkg::CFG_DOT_MIN:  r_cfg.dot_min  <= i_cfg.data;
                mced_pkg::CFG_DASH_MIN: r_cfg.dash_min <= i_cfg.data;
                mced_pkg::CFG_GAP_MIN:  r_cfg.gap_min  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    mced_core #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in.valid),
        .o_in_ready     (i_in.ready),
        .i_capture_value(i_in.capture_value),
        .i_wraps        (i_in.wraps),
        .i_rq_status    (rq_status),
        .o_push         (push),
        .o_res0         (res0),
        .o_res1         (res1)
    );

    mced_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_status(rq_status),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_res   (out_res)
    );

    assign o_out.char_valid  = out_res.char_valid;
    assign o_out.char_code   = out_res.char_code;
    assign o_out.dot_lamp    = out_res.dot_lamp;
    assign o_out.dash_lamp   = out_res.dash_lamp;
    assign o_out.last_result = out_res.last_result;

    // A result that carries no character is always the only one of its edge.
    a_nochar_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.char_valid) |-> o_out.last_result)
        else $error("result without character is not the last of its edge");

    // The first of two results is always the space.
    a_first_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last_result) |->
            (o_out.char_valid && (o_out.char_code == mced_pkg::ASCII_SPACE)))
        else $error("first of two results is not a space");

    // A press is never both a dot and a dash.
    a_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.dot_lamp && o_out.dash_lamp))
        else $error("dot and dash lamps lit together");

    // A character result never lights a lamp.
    a_char_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.char_valid) |-> (!o_out.dot_lamp && !o_out.dash_lamp))
        else $error("lamp lit on a character result");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the Morse edge timing decoder: random key edges against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int MAX_SYMBOLS  = mced_pkg::MAX_SYMBOLS_DEF;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam int LIMIT_NS     = 5_000_000;
    localparam logic [mced_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    class morse_scoreboard;
        logic [mced_pkg::TICK_W-1:0] dot_min;
        logic [mced_pkg::TICK_W-1:0] dash_min;
        logic [mced_pkg::TICK_W-1:0] gap_min;
        bit                          expect_rising;
        logic [mced_pkg::CAP_W-1:0]  last_edge;
        int unsigned                 sym_count;
        logic [7:0]                  sym_pattern;
        bit                          too_long;
        mced_pkg::t_result           expected_q[$];
        int                          errors;
        string                       code_table[36];
        string                       char_table;

        function new();
            code_table = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
                           ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
                           "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
                           ".----", "..---", "...--", "....-", ".....", "-....", "--...",
                           "---..", "----.", "-----"};
            char_table = "ABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";
            dot_min = mced_pkg::DOT_MIN_RST;
            dash_min = mced_pkg::DASH_MIN_RST;
            gap_min = mced_pkg::GAP_MIN_RST;
            expect_rising = 1'b1;
            last_edge = '0;
            sym_count = 0;
            sym_pattern = '0;
            too_long = 1'b0;
            errors = 0;
        endfunction

        function void set_threshold(logic [mced_pkg::CFG_IDX_W-1:0] idx,
                                    logic [mced_pkg::TICK_W-1:0] val);
            case (idx)
                mced_pkg::CFG_DOT_MIN:  dot_min = val;
                mced_pkg::CFG_DASH_MIN: dash_min = val;
                mced_pkg::CFG_GAP_MIN:  gap_min = val;
                default: ;
            endcase
        endfunction

        function logic [mced_pkg::CHAR_W-1:0] decode_letter();
            string      s;
            logic [7:0] pat;
            if (too_long || sym_count == 0)
                return '0;
            for (int e = 0; e < 36; e++) begin
                s = code_table[e];
                if (s.len() != sym_count)
                    continue;
                pat = '0;
                for (int i = 0; i < s.len(); i++)
                    pat[i] = (s[i] == "-");
                if (pat == sym_pattern)
                    return mced_pkg::CHAR_W'(char_table[e]);
            end
            return '0;
        endfunction

        function void push_result(bit cv, logic [mced_pkg::CHAR_W-1:0] code, bit dot,
                                  bit dash, bit last);
            mced_pkg::t_result r;
            r.char_valid = cv;
            r.char_code = code;
            r.dot_lamp = dot;
            r.dash_lamp = dash;
            r.last_result = last;
            expected_q.push_back(r);
        endfunction

        function void note_edge(logic [mced_pkg::CAP_W-1:0] cap,
                                logic [mced_pkg::WRAP_W-1:0] wr);
            longint                      el;
            bit                          nonneg;
            bit                          dot;
            bit                          dash;
            logic [mced_pkg::CHAR_W-1:0] ch;
            el = longint'(wr) * 65536 + longint'(cap) - longint'(last_edge);
            nonneg = (el >= 0);
            last_edge = cap;
            if (expect_rising) begin
                expect_rising = 1'b0;
                if (nonneg && el >= longint'(gap_min)) begin
                    ch = decode_letter();
                    sym_count = 0;
                    sym_pattern = '0;
                    too_long = 1'b0;
                    push_result(1'b1, mced_pkg::ASCII_SPACE, 1'b0, 1'b0, ch == '0);
                    if (ch != '0)
                        push_result(1'b1, ch, 1'b0, 1'b0, 1'b1);
                end else begin
                    push_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
                end
            end else begin
                expect_rising = 1'b1;
                dot = nonneg && el >= longint'(dot_min) && el < longint'(dash_min);
                dash = nonneg && !dot && el >= longint'(dash_min);
                if (dot || dash) begin
                    if (sym_count < MAX_SYMBOLS) begin
                        sym_pattern[sym_count] = dash;
                        sym_count++;
                    end else begin
                        too_long = 1'b1;
                    end
                end
                push_result(1'b0, '0, dot, dash, 1'b1);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(mced_pkg::t_result got);
            mced_pkg::t_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("char_valid", want.char_valid, got.char_valid);
            compare_field("char_code", want.char_code, got.char_code);
            compare_field("dot_lamp", want.dot_lamp, got.dot_lamp);
            compare_field("dash_lamp", want.dash_lamp, got.dash_lamp);
            compare_field("last_result", want.last_result, got.last_result);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mced_in_if  edge_if ();
    mced_out_if res_if ();
    mced_cfg_if cfg_if ();

    morse_edge_timing_decoder DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (edge_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    morse_scoreboard            sb;
    bit                         tx_idle_en;
    bit                         rx_idle_en;
    int unsigned                rx_hold;
    int unsigned                long_hold_asked;
    int unsigned                long_hold_taken;
    int unsigned                items_sent;
    logic [mced_pkg::CAP_W-1:0] drv_last_cap;
    bit                         drv_rising;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        int unsigned hold_next;
        if (rx_hold != 0) begin
            hold_next = rx_hold - 1;
        end else if (long_hold_taken != long_hold_asked) begin
            hold_next = LONG_HOLD;
            long_hold_taken <= long_hold_asked;
        end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            hold_next = $urandom_range(1, 7);
        end else begin
            hold_next = 0;
        end
        rx_hold <= hold_next;
        res_if.ready <= (hold_next == 0);
    end

    always @(posedge clk) begin
        mced_pkg::t_result got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.char_valid = res_if.char_valid;
            got.char_code = res_if.char_code;
            got.dot_lamp = res_if.dot_lamp;
            got.dash_lamp = res_if.dash_lamp;
            got.last_result = res_if.last_result;
            sb.check_result(got);
        end
    end

    task automatic send_edge(input logic [mced_pkg::CAP_W-1:0] cap,
                             input logic [mced_pkg::WRAP_W-1:0] wr);
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            edge_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        edge_if.valid <= 1'b1;
        edge_if.capture_value <= cap;
        edge_if.wraps <= wr;
        do @(posedge clk); while (!edge_if.ready);
        sb.note_edge(cap, wr);
        drv_last_cap = cap;
        drv_rising = !drv_rising;
        items_sent++;
    endtask

    task automatic send_elapsed(input int unsigned span);
        int unsigned total;
        total = span + drv_last_cap;
        if (total > 32'h00FF_FFFF)
            total = 32'h00FF_FFFF;
        send_edge(total[15:0], total[23:16]);
    endtask

    function automatic int unsigned press_len(bit dash_sym);
        if (dash_sym || sb.dot_min >= sb.dash_min)
            return sb.dash_min + $urandom_range(0, 4000);
        return $urandom_range(sb.dash_min - 1, sb.dot_min);
    endfunction

    function automatic int unsigned gap_len(bit long_gap);
        if (long_gap || sb.gap_min == 0)
            return sb.gap_min + $urandom_range(0, 4000);
        return $urandom_range(sb.gap_min - 1, 0);
    endfunction

    task automatic send_noise();
        send_edge(mced_pkg::CAP_W'($urandom),
                  ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom));
    endtask

    // A letter is a long release, then presses separated by short releases.
    task automatic send_letter();
        int unsigned n_sym;
        logic [7:0]  pat;
        string       s;
        if (!drv_rising)
            send_elapsed(press_len($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) begin
            s = sb.code_table[$urandom_range(0, 35)];
            n_sym = s.len();
            pat = '0;
            for (int i = 0; i < s.len(); i++)
                pat[i] = (s[i] == "-");
        end else begin
            n_sym = $urandom_range(1, 7);
            pat = 8'($urandom);
        end
        send_elapsed(gap_len(1'b1));
        for (int i = 0; i < n_sym; i++) begin
            if (i > 0)
                send_elapsed(gap_len(1'b0));
            send_elapsed(press_len(pat[i]));
        end
    endtask

    task automatic run_traffic(input int unsigned n_items);
        int unsigned target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_letter();
        end
        edge_if.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mced_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mced_pkg::TICK_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge clk); while (!cfg_if.ready);
        sb.set_threshold(idx, val);
    endtask

    task automatic set_thresholds(input logic [mced_pkg::TICK_W-1:0] dot,
                                  input logic [mced_pkg::TICK_W-1:0] dash,
                                  input logic [mced_pkg::TICK_W-1:0] gap);
        write_reg(mced_pkg::CFG_DOT_MIN, dot);
        write_reg(mced_pkg::CFG_DASH_MIN, dash);
        write_reg(CFG_IDX_SPARE, mced_pkg::TICK_W'($urandom));
        write_reg(mced_pkg::CFG_GAP_MIN, gap);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        #LIMIT_NS;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        edge_if.valid = 1'b0;
        edge_if.capture_value = '0;
        edge_if.wraps = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        res_if.ready = 1'b1;
        rx_hold = 0;
        long_hold_asked = 0;
        long_hold_taken = 0;
        items_sent = 0;
        drv_last_cap = '0;
        drv_rising = 1'b1;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Thresholds hit exactly, the digit zero, a short press, negative elapsed times,
        // the largest possible edge and a sixth symbol that overflows the code.
        send_edge('0, '0);
        send_elapsed(mced_pkg::DOT_MIN_RST);
        send_elapsed(mced_pkg::GAP_MIN_RST);
        for (int i = 0; i < 5; i++) begin
            if (i > 0)
                send_elapsed(mced_pkg::GAP_MIN_RST - 1);
            send_elapsed(mced_pkg::DASH_MIN_RST + i);
        end
        send_elapsed(mced_pkg::GAP_MIN_RST + 7);
        send_elapsed(mced_pkg::DOT_MIN_RST - 1);
        send_edge(drv_last_cap - 16'd1, '0);
        send_edge(16'hFFFF, 8'hFF);
        send_edge(16'hFFFF, '0);
        send_edge('0, '0);
        repeat (4) begin
            send_elapsed(gap_len(1'b0));
            send_elapsed(press_len(1'b0));
        end
        send_elapsed(gap_len(1'b0));
        send_elapsed(press_len(1'b1));
        send_elapsed(gap_len(1'b1));

        run_traffic(200);
        wait_idle();

        set_thresholds(24'd20, 24'd60, 24'd100);
        tx_idle_en = 1'b0;
        long_hold_asked <= long_hold_asked + 1;
        run_traffic(150);
        wait_idle();

        tx_idle_en = 1'b1;
        set_thresholds(mced_pkg::TICK_W'($urandom_range(30000, 0)),
                       mced_pkg::TICK_W'($urandom_range(60000, 0)),
                       mced_pkg::TICK_W'($urandom_range(80000, 0)));
        run_traffic(150);
        wait_idle();

        set_thresholds(24'd5000, 24'd3000, 24'd9000);
        run_traffic(100);
        wait_idle();

        set_thresholds('0, '0, '0);
        run_traffic(100);
        wait_idle();

        set_thresholds('1, '1, '1);
        run_traffic(100);
        wait_idle();

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_thresholds(mced_pkg::DOT_MIN_RST, mced_pkg::DASH_MIN_RST, mced_pkg::GAP_MIN_RST);
        run_traffic(200);
        wait_idle();

        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mced_pkg.sv
hw/rtl/mced_if.sv
hw/rtl/mced_core.sv
hw/rtl/mced_rq.sv
hw/rtl/morse_edge_timing_decoder.sv
sim/tb_top.sv
